// File: sv/nak_missing_page_tracker_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the missing-page tracker
// Clocked property checks, one form of which reset switches off. Define ASSERT_OFF to
// drop every check.
// ---------------------------------------------------------------------------
`ifndef NAK_MISSING_PAGE_TRACKER_MACROS_SVH
`define NAK_MISSING_PAGE_TRACKER_MACROS_SVH

`ifndef ASSERT_OFF
// Check prop at every rising edge of clk while rst is low.
`define NMPT_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: property check failed");
// Check prop at every rising edge of clk, reset included.
`define NMPT_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("%m: property check failed");
`else
`define NMPT_ASSERT(label, clk, rst, prop)
`define NMPT_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// File: sv/nmpt_pkg.sv
// ---------------------------------------------------------------------------
// Missing-page tracker package
// Word types, operation and complaint codes, register indexes and resets.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package nmpt_pkg;

   localparam int PAGE_W     = 11;
   localparam int WAIT_W     = 16;
   localparam int RETRY_W    = 8;
   localparam int TOTAL_W    = 32;
   localparam int CMP_W      = 17;  // holds any page bound up to 65536
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [PAGE_W-1:0]  PAGE_COUNT_RST  = 11'd1024;
   localparam logic [WAIT_W-1:0]  WAIT_TICKS_RST  = 16'd1000;
   localparam logic [RETRY_W-1:0] RETRY_LIMIT_RST = 8'd5;

   typedef enum logic [2:0] {
      OP_COMPLAINT   = 3'd0,
      OP_PAGE_RESENT = 3'd1,
      OP_QUERY_PAGE  = 3'd2,
      OP_TICK        = 3'd3,
      OP_ARM_WAIT    = 3'd4,
      OP_CLEAR_ALL   = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      CC_PAGE_RECEIVED = 3'd0,
      CC_START_OK      = 3'd1,
      CC_EOF_OK        = 3'd2,
      CC_MISSING_PAGE  = 3'd3,
      CC_LAST_MISSING  = 3'd4
   } complaint_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PAGE_COUNT  = 2'd0,
      CSR_WAIT_TICKS  = 2'd1,
      CSR_RETRY_LIMIT = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic [2:0]        operation;
      logic [2:0]        complaint_code;
      logic              frame_ok;
      logic [PAGE_W-1:0] page;
   } req_type;

   typedef struct packed {
      logic               handled;
      logic               page_missing;
      logic               any_missing;
      logic [TOTAL_W-1:0] missing_reports;
      logic               peer_ready;
      logic               resend;
      logic               timed_out;
   } rsp_type;

endpackage

// File: sv/nmpt_ram.sv
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module nmpt_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// File: sv/nak_missing_page_tracker.sv
// ---------------------------------------------------------------------------
// Missing-page tracker
// Sender-side bookkeeping of receiver complaints, missing pages and the
// acknowledgement wait of a reliable multicast transfer.
// ---------------------------------------------------------------------------
// For each accepted word the bitmap RAM is read in the cycle of acceptance, and
// the entry is modified and written back in ST_EXEC, which also loads the
// result register. A result that waits to be taken does not stop the next
// word from being accepted; that word holds in ST_EXEC until the result
// register frees. A clear-all word delivers its result and then sweeps the
// bitmap, one entry a cycle, with req_stall high. The same sweep runs after
// reset before the first word is taken. Register writes are taken in any
// cycle but should only be issued while no word is in flight.
`timescale 1ns / 1ps
`include "nak_missing_page_tracker_macros.svh"

module nak_missing_page_tracker
   import nmpt_pkg::*;
#(
   parameter int MAX_PAGES = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   // complaint / command words
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   // result words
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   // register writes
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   localparam int AW = $clog2(MAX_PAGES);       // bitmap address
   localparam int CW = $clog2(MAX_PAGES + 1);   // count of marked pages

   localparam logic [CMP_W-1:0] MAX_PAGES_W = CMP_W'(MAX_PAGES);
   localparam logic [AW-1:0]    LAST_ADDR   = AW'(MAX_PAGES - 1);

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   state_type            state_ff,        state_in;
   logic [AW-1:0]        sweep_addr_ff,   sweep_addr_in;

   req_type              item_ff;
   logic [AW-1:0]        item_addr_ff;

   logic                 rsp_valid_ff,    rsp_valid_in;
   rsp_type              rsp_ff,          rsp_in;

   logic [PAGE_W-1:0]    page_count_ff;
   logic [WAIT_W-1:0]    wait_ticks_ff;
   logic [RETRY_W-1:0]   retry_limit_ff;

   logic [CW-1:0]        marked_count_ff, marked_count_in;
   logic [TOTAL_W-1:0]   report_total_ff, report_total_in;
   logic                 ready_ff,        ready_in;
   logic                 waiting_ff,      waiting_in;
   logic [WAIT_W-1:0]    elapsed_ff,      elapsed_in;
   logic [RETRY_W-1:0]   expiry_ff,       expiry_in;

   // ---------------------------------------------------------------------
   // Control and datapath nets
   // ---------------------------------------------------------------------
   logic                 out_free;
   logic                 req_accept;
   logic                 exec_fire;
   logic                 sweep_last;

   logic                 ram_wr_en;
   logic [AW-1:0]        ram_wr_addr;
   logic                 ram_wr_data;
   logic [AW-1:0]        ram_rd_addr;
   logic                 ram_rd_data;

   logic [AW-1:0]        req_addr;
   logic [CMP_W-1:0]     item_page_w;
   logic [CMP_W-1:0]     page_limit;
   logic                 report_in_range;
   logic                 page_in_store;

   logic                 bit_wr;
   logic                 bit_value;
   logic                 handled;
   logic                 page_missing;
   logic                 resend;
   logic                 timed_out;
   logic [WAIT_W-1:0]    elapsed_inc;
   logic [RETRY_W-1:0]   expiry_inc;

   // ---------------------------------------------------------------------
   // Bitmap of missing pages
   // ---------------------------------------------------------------------
   nmpt_ram #(
      .WIDTH (1),
      .DEPTH (MAX_PAGES)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Complaints carry one-based pages, resend and query carry zero-based.
   // Out-of-range pages alias harmlessly; the checks below drop them.
   assign req_addr = (req_data.operation == OP_COMPLAINT)
                   ? AW'(CMP_W'(req_data.page) - CMP_W'(1))
                   : AW'(CMP_W'(req_data.page));

   assign item_page_w     = CMP_W'(item_ff.page);
   assign page_limit      = (CMP_W'(page_count_ff) > MAX_PAGES_W)
                          ? MAX_PAGES_W : CMP_W'(page_count_ff);
   assign report_in_range = (item_page_w != '0) && (item_page_w <= page_limit);
   assign page_in_store   = item_page_w < MAX_PAGES_W;

   // ---------------------------------------------------------------------
   // Handshake
   // ---------------------------------------------------------------------
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign exec_fire  = (state_ff == ST_EXEC) && out_free;
   assign sweep_last = sweep_addr_ff == LAST_ADDR;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   // ---------------------------------------------------------------------
   // Sequencer: next state
   // ---------------------------------------------------------------------
   always_comb begin : next_state
      state_in = state_ff;
      unique case (state_ff)
         ST_SWEEP: begin
            if (sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (exec_fire) begin
               state_in = (item_ff.operation == OP_CLEAR_ALL) ? ST_SWEEP : ST_IDLE;
            end
         end
         default: state_in = ST_SWEEP;
      endcase
   end

   // ---------------------------------------------------------------------
   // Sequencer: outputs and RAM control
   // ---------------------------------------------------------------------
   always_comb begin : seq_outputs
      req_stall     = 1'b1;
      sweep_addr_in = sweep_addr_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = item_addr_ff;
      ram_wr_data   = bit_value;
      // Keep re-reading the held entry so the data survives an output stall.
      ram_rd_addr   = item_addr_ff;
      unique case (state_ff)
         ST_SWEEP: begin
            ram_wr_en     = 1'b1;
            ram_wr_addr   = sweep_addr_ff;
            ram_wr_data   = 1'b0;
            sweep_addr_in = sweep_last ? '0 : sweep_addr_ff + AW'(1);
         end
         ST_IDLE: begin
            req_stall   = 1'b0;
            ram_rd_addr = req_addr;
         end
         ST_EXEC: begin
            ram_wr_en = exec_fire && bit_wr;
         end
         default: ;
      endcase
   end

   // ---------------------------------------------------------------------
   // Per-word update: modify the bitmap entry and the scalar state
   // ---------------------------------------------------------------------
   assign elapsed_inc = (elapsed_ff != '1) ? elapsed_ff + WAIT_W'(1) : elapsed_ff;

   always_comb begin : word_update
      marked_count_in = marked_count_ff;
      report_total_in = report_total_ff;
      ready_in        = ready_ff;
      waiting_in      = waiting_ff;
      elapsed_in      = elapsed_ff;
      expiry_in       = expiry_ff;
      expiry_inc      = expiry_ff;
      bit_wr          = 1'b0;
      bit_value       = 1'b0;
      handled         = 1'b0;
      page_missing    = 1'b0;
      resend          = 1'b0;
      timed_out       = 1'b0;

      if (exec_fire) begin
         unique case (item_ff.operation)
            OP_COMPLAINT: begin
               if (item_ff.frame_ok) begin
                  unique case (item_ff.complaint_code) inside
                     CC_PAGE_RECEIVED: begin
                        handled = 1'b1;
                     end
                     CC_START_OK, CC_EOF_OK: begin
                        handled    = 1'b1;
                        ready_in   = 1'b1;
                        waiting_in = 1'b0;
                     end
                     CC_MISSING_PAGE, CC_LAST_MISSING: begin
                        handled = 1'b1;
                        if (report_in_range) begin
                           // mark once, count every report
                           if (!ram_rd_data) begin
                              bit_wr          = 1'b1;
                              bit_value       = 1'b1;
                              marked_count_in = marked_count_ff + CW'(1);
                           end
                           if (report_total_ff != '1) begin
                              report_total_in = report_total_ff + TOTAL_W'(1);
                           end
                           if (item_ff.complaint_code == CC_LAST_MISSING) begin
                              ready_in   = 1'b1;
                              waiting_in = 1'b0;
                           end
                        end
                     end
                     default: ;
                  endcase
                  if (handled && waiting_in) begin
                     elapsed_in = '0;
                  end
               end
            end
            OP_PAGE_RESENT: begin
               if (page_in_store && ram_rd_data) begin
                  bit_wr          = 1'b1;
                  bit_value       = 1'b0;
                  marked_count_in = marked_count_ff - CW'(1);
               end
            end
            OP_QUERY_PAGE: begin
               page_missing = page_in_store && ram_rd_data;
            end
            OP_TICK: begin
               if (waiting_ff && !ready_ff) begin
                  elapsed_in = elapsed_inc;
                  if (elapsed_inc >= wait_ticks_ff) begin
                     expiry_inc = (expiry_ff != '1) ? expiry_ff + RETRY_W'(1) : expiry_ff;
                     expiry_in  = expiry_inc;
                     if (expiry_inc < retry_limit_ff) begin
                        resend     = 1'b1;
                        elapsed_in = '0;
                     end else begin
                        timed_out  = 1'b1;
                        waiting_in = 1'b0;
                     end
                  end
               end
            end
            OP_ARM_WAIT: begin
               ready_in   = 1'b0;
               waiting_in = 1'b1;
               elapsed_in = '0;
               expiry_in  = '0;
            end
            OP_CLEAR_ALL: begin
               // the sweep that follows clears the entries themselves
               marked_count_in = '0;
            end
            default: ;
         endcase
      end

      rsp_in.handled         = handled;
      rsp_in.page_missing    = page_missing;
      rsp_in.any_missing     = marked_count_in != '0;
      rsp_in.missing_reports = report_total_in;
      rsp_in.peer_ready      = ready_in;
      rsp_in.resend          = resend;
      rsp_in.timed_out       = timed_out;

      // drop the held result once taken, load the new one when produced
      rsp_valid_in = exec_fire ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   // ---------------------------------------------------------------------
   // Control state
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_SWEEP;
         sweep_addr_ff   <= '0;
         rsp_valid_ff    <= 1'b0;
         page_count_ff   <= PAGE_COUNT_RST;
         wait_ticks_ff   <= WAIT_TICKS_RST;
         retry_limit_ff  <= RETRY_LIMIT_RST;
         marked_count_ff <= '0;
         report_total_ff <= '0;
         ready_ff        <= 1'b0;
         waiting_ff      <= 1'b0;
         elapsed_ff      <= '0;
         expiry_ff       <= '0;
      end else begin
         state_ff        <= state_in;
         sweep_addr_ff   <= sweep_addr_in;
         rsp_valid_ff    <= rsp_valid_in;
         marked_count_ff <= marked_count_in;
         report_total_ff <= report_total_in;
         ready_ff        <= ready_in;
         waiting_ff      <= waiting_in;
         elapsed_ff      <= elapsed_in;
         expiry_ff       <= expiry_in;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_PAGE_COUNT:  page_count_ff  <= csr_wr_data[PAGE_W-1:0];
               CSR_WAIT_TICKS:  wait_ticks_ff  <= csr_wr_data[WAIT_W-1:0];
               CSR_RETRY_LIMIT: retry_limit_ff <= csr_wr_data[RETRY_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------
   // Payload: held word and result register
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff      <= req_data;
         item_addr_ff <= req_addr;
      end
      if (exec_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   // ---------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------
   // a new result only ever follows the write-back cycle of a word
   `NMPT_ASSERT(a_rsp_from_exec, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == ST_EXEC))
   // the live count can never pass the number of bitmap entries
   `NMPT_ASSERT(a_count_bound, clock, reset, marked_count_ff <= CW'(MAX_PAGES))
   // setting ready ends the wait and arming clears ready
   `NMPT_ASSERT(a_ready_xor_wait, clock, reset, !(ready_ff && waiting_ff))
   // a timeout abandons the wait
   `NMPT_ASSERT(a_timeout_ends_wait, clock, reset, (exec_fire && timed_out) |=> !waiting_ff)

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Missing-page tracker regression
// Drives complaint and command words into the tracker and checks every
// result word against a cycle-free model of the bitmap, the report total
// and the acknowledgement wait. A short table of directed words runs first.
// Randomised phases follow, each with its own register settings and one of
// three patterns of sender and receiver idling.
// ---------------------------------------------------------------------------

module testbench;
   import nmpt_pkg::*;

   localparam int MAX_PAGES       = 1024;
   localparam int ITEMS_PER_PHASE = 304;
   localparam int PHASES          = 6;
   // A clear-all sweeps the bitmap after its result, so give it room to finish
   localparam int SETTLE_CYCLES   = MAX_PAGES + 16;

   // Codes the package leaves unnamed: spare operations and unknown complaints
   localparam logic [2:0] OP_SPARE_LO   = 3'd6;
   localparam logic [2:0] OP_SPARE_HI   = 3'd7;
   localparam logic [2:0] CC_UNKNOWN_LO = 3'd5;
   localparam logic [2:0] CC_UNKNOWN_HI = 3'd7;

   localparam rsp_type RSP_QUIET = '0;

   typedef struct packed {
      req_type w;
      logic    typed;
      rsp_type want;
   } directed_row_type;

   logic                  clock;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   req_type               req_data    = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_wr_en   = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index   = '0;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;

   // Idling odds in percent, changed per phase
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   bit          fault_seen    = 1'b0;

   // Register settings of the random phases: extremes first, then mixed
   int unsigned phase_pages   [PHASES] = '{1, 1024, 16, 64, 300, 7};
   int unsigned phase_ticks   [PHASES] = '{1, 65535, 3, 2, 5, 1};
   int unsigned phase_retries [PHASES] = '{1, 255, 4, 255, 2, 3};

   // Tracker model state
   bit          page_marked [0:MAX_PAGES-1];
   int unsigned marked_pages    = 0;
   logic [31:0] report_total    = '0;
   bit          ready_flag      = 1'b0;
   bit          wait_armed      = 1'b0;
   int unsigned elapsed_ticks   = 0;
   int unsigned expiry_count    = 0;
   int unsigned cfg_page_count  = 32'(PAGE_COUNT_RST);
   int unsigned cfg_wait_ticks  = 32'(WAIT_TICKS_RST);
   int unsigned cfg_retry_limit = 32'(RETRY_LIMIT_RST);

   // Status words still owed by the tracker, oldest first
   rsp_type expected_status [$];

   nak_missing_page_tracker #(
      .MAX_PAGES(MAX_PAGES)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Guard against a hung handshake: far beyond the slowest correct run
   initial begin : watchdog
      #2_000_000;
      $display("nak_missing_page_tracker regression: fail");
      $finish;
   end

   // Apply one word to the model and return the status word it must produce
   function automatic rsp_type track_word(req_type w);
      rsp_type     r;
      int unsigned limit;
      r = '0;
      limit = (cfg_page_count > MAX_PAGES) ? MAX_PAGES : cfg_page_count;
      case (w.operation)
         OP_COMPLAINT: begin
            if (w.frame_ok) begin
               r.handled = 1'b1;
               case (w.complaint_code)
                  CC_PAGE_RECEIVED: ;
                  CC_START_OK, CC_EOF_OK: begin
                     ready_flag = 1'b1;
                     wait_armed = 1'b0;
                  end
                  CC_MISSING_PAGE, CC_LAST_MISSING: begin
                     // page zero or beyond the transfer: accepted, otherwise ignored
                     if (w.page != 0 && w.page <= limit) begin
                        if (!page_marked[w.page - 1]) begin
                           page_marked[w.page - 1] = 1'b1;
                           marked_pages++;
                        end
                        if (report_total != '1)
                           report_total++;
                        if (w.complaint_code == CC_LAST_MISSING) begin
                           ready_flag = 1'b1;
                           wait_armed = 1'b0;
                        end
                     end
                  end
                  default: r.handled = 1'b0;
               endcase
               // a handled complaint restarts the wait clock
               if (r.handled && wait_armed)
                  elapsed_ticks = 0;
            end
         end
         OP_PAGE_RESENT: begin
            if (w.page < MAX_PAGES && page_marked[w.page]) begin
               page_marked[w.page] = 1'b0;
               marked_pages--;
            end
         end
         OP_QUERY_PAGE: begin
            if (w.page < MAX_PAGES)
               r.page_missing = page_marked[w.page];
         end
         OP_TICK: begin
            if (wait_armed && !ready_flag) begin
               if (elapsed_ticks < 16'hFFFF)
                  elapsed_ticks++;
               if (elapsed_ticks >= cfg_wait_ticks) begin
                  if (expiry_count < 8'hFF)
                     expiry_count++;
                  if (expiry_count < cfg_retry_limit) begin
                     r.resend = 1'b1;
                     elapsed_ticks = 0;
                  end else begin
                     r.timed_out = 1'b1;
                     wait_armed = 1'b0;
                  end
               end
            end
         end
         OP_ARM_WAIT: begin
            ready_flag    = 1'b0;
            wait_armed    = 1'b1;
            elapsed_ticks = 0;
            expiry_count  = 0;
         end
         OP_CLEAR_ALL: begin
            foreach (page_marked[i])
               page_marked[i] = 1'b0;
            marked_pages = 0;
         end
         default: ;
      endcase
      r.any_missing     = (marked_pages != 0);
      r.missing_reports = report_total;
      r.peer_ready      = ready_flag;
      return r;
   endfunction

   function automatic req_type word_of(logic [2:0] op, logic [2:0] code, logic fok,
                                       logic [PAGE_W-1:0] page);
      req_type w;
      w.operation      = op;
      w.complaint_code = code;
      w.frame_ok       = fok;
      w.page           = page;
      return w;
   endfunction

   // Mostly well-formed complaints and ticks, with short frames, unknown
   // codes, out-of-range pages and spare operations mixed in
   function automatic req_type random_word();
      req_type     w;
      int unsigned pick;
      w.complaint_code = 3'($urandom_range(0, 7));
      w.frame_ok       = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 99);
      if (pick < 38) begin
         w.operation = OP_COMPLAINT;
         w.frame_ok  = ($urandom_range(0, 9) != 0);
         pick = $urandom_range(0, 9);
         if (pick < 5)
            w.complaint_code = CC_MISSING_PAGE;
         else if (pick == 5)
            w.complaint_code = CC_LAST_MISSING;
         else if (pick == 6)
            w.complaint_code = CC_PAGE_RECEIVED;
         else if (pick == 7)
            w.complaint_code = $urandom_range(0, 1) ? CC_START_OK : CC_EOF_OK;
         else
            w.complaint_code = 3'($urandom_range(CC_UNKNOWN_LO, CC_UNKNOWN_HI));
      end else if (pick < 50) begin
         w.operation = OP_PAGE_RESENT;
      end else if (pick < 65) begin
         w.operation = OP_QUERY_PAGE;
      end else if (pick < 88) begin
         w.operation = OP_TICK;
      end else if (pick < 94) begin
         w.operation = OP_ARM_WAIT;
      end else if (pick < 97) begin
         w.operation = OP_CLEAR_ALL;
      end else begin
         w.operation = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      end
      // keep most pages near the transfer size so reports and resends collide
      pick = $urandom_range(0, 99);
      if (pick < 80)
         w.page = PAGE_W'($urandom_range(0, cfg_page_count + 1));
      else if (pick < 95)
         w.page = PAGE_W'($urandom_range(0, MAX_PAGES));
      else
         w.page = PAGE_W'($urandom_range(0, (1 << PAGE_W) - 1));
      return w;
   endfunction

   function automatic void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         fault_seen = 1'b1;
      end
   endfunction

   // Present one word, hold it until taken, then log what it must produce
   task automatic send_word(req_type w, logic typed, rsp_type typed_status);
      rsp_type status;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
      status = track_word(w);
      expected_status.push_back(typed ? typed_status : status);
   endtask

   // Write all three registers on consecutive edges; only called while idle
   task automatic load_settings(int unsigned pages, int unsigned ticks,
                                int unsigned retries);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_PAGE_COUNT;
      csr_wr_data <= pages[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_index   <= CSR_WAIT_TICKS;
      csr_wr_data <= ticks[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_index   <= CSR_RETRY_LIMIT;
      csr_wr_data <= retries[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      cfg_page_count  = pages;
      cfg_wait_ticks  = ticks;
      cfg_retry_limit = retries;
   endtask

   // Drop valid, wait for every owed word, then let any sweep run out
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_status.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Take result words and compare them with the oldest expectation
   always @(posedge clock) begin : take_results
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_status.size() == 0) begin
            $error("result word with no expectation waiting");
            fault_seen = 1'b1;
         end else begin
            want = expected_status.pop_front();
            compare_field("handled", want.handled, rsp_data.handled);
            compare_field("page_missing", want.page_missing, rsp_data.page_missing);
            compare_field("any_missing", want.any_missing, rsp_data.any_missing);
            compare_field("missing_reports", want.missing_reports,
                          rsp_data.missing_reports);
            compare_field("peer_ready", want.peer_ready, rsp_data.peer_ready);
            compare_field("resend", want.resend, rsp_data.resend);
            compare_field("timed_out", want.timed_out, rsp_data.timed_out);
         end
      end
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
   end

   initial begin : stimulus
      directed_row_type directed_table [$];
      rsp_type          handled_only;
      req_type          w;

      handled_only = '0;
      handled_only.handled = 1'b1;

      // Directed words, run with four pages, a two-tick wait and two expiries.
      // The first rows leave the model in its reset state, so their status is
      // plain: a query, dropped or unknown complaints, ignored reports, an idle tick.
      directed_table.push_back(directed_row_type'{
         word_of(OP_QUERY_PAGE, CC_PAGE_RECEIVED, 1'b0, 11'd0), 1'b1, RSP_QUIET});
      directed_table.push_back(directed_row_type'{
         word_of(OP_COMPLAINT, CC_MISSING_PAGE, 1'b0, 11'd1), 1'b1, RSP_QUIET});
      directed_table.push_back(directed_row_type'{
         word_of(OP_COMPLAINT, CC_UNKNOWN_HI, 1'b1, 11'd1), 1'b1, RSP_QUIET});
      directed_table.push_back(directed_row_type'{
         word_of(OP_COMPLAINT, CC_MISSING_PAGE, 1'b1, 11'd0), 1'b1, handled_only});
      directed_table.push_back(directed_row_type'{
         word_of(OP_COMPLAINT, CC_LAST_MISSING, 1'b1, 11'd5), 1'b1, handled_only});
      directed_table.push_back(directed_row_type'{
         word_of(OP_TICK, CC_PAGE_RECEIVED, 1'b0, 11'd0), 1'b1, RSP_QUIET});
      // marking, repeat report, last page of the transfer
      directed_table.push_back(directed_row_type'{
         word_of(OP_COMPLAINT, CC_MISSING_PAGE, 1'b1, 11'd1), 1'b0, RSP_QUIET});
      directed_table.push_back(directed_row_type'{
         word_of(OP_COMPLAINT, CC_MISSING_PAGE, 1'b1, 11'd1), 1'b0, RSP_QUIET});
      directed_table.push_back(directed_row_type'{
         word_of(OP_COMPLAINT, CC_LAST_MISSING, 1'b1, 11'd4), 1'b0, RSP_QUIET});
      // query and resend, in range and past the bitmap
      directed_table.push_back(directed_row_type'{
         word_of(OP_QUERY_PAGE, CC_PAGE_RECEIVED, 1'b0, 11'd0), 1'b0, RSP_QUIET});
      directed_table.push_back(directed_row_type'{
         word_of(OP_QUERY_PAGE, CC_PAGE_RECEIVED, 1'b0, 11'd1024), 1'b0, RSP_QUIET});
      directed_table.push_back(directed_row_type'{
         word_of(OP_PAGE_RESENT, CC_PAGE_RECEIVED, 1'b0, 11'd0), 1'b0, RSP_QUIET});
      directed_table.push_back(directed_row_type'{
         word_of(OP_PAGE_RESENT, CC_PAGE_RECEIVED, 1'b0, 11'd1024), 1'b0, RSP_QUIET});
      directed_table.push_back(directed_row_type'{
         word_of(OP_COMPLAINT, CC_START_OK, 1'b1, 11'd0), 1'b0, RSP_QUIET});
      // arm, restart the clock with a complaint, then resend and time out
      directed_table.push_back(directed_row_type'{
         word_of(OP_ARM_WAIT, CC_PAGE_RECEIVED, 1'b0, 11'd0), 1'b0, RSP_QUIET});
      directed_table.push_back(directed_row_type'{
         word_of(OP_TICK, CC_PAGE_RECEIVED, 1'b0, 11'd0), 1'b0, RSP_QUIET});
      directed_table.push_back(directed_row_type'{
         word_of(OP_COMPLAINT, CC_PAGE_RECEIVED, 1'b1, 11'd3), 1'b0, RSP_QUIET});
      repeat (4)
         directed_table.push_back(directed_row_type'{
            word_of(OP_TICK, CC_PAGE_RECEIVED, 1'b0, 11'd0), 1'b0, RSP_QUIET});
      // an acknowledgement ends a fresh wait; then clear and spare operations
      directed_table.push_back(directed_row_type'{
         word_of(OP_ARM_WAIT, CC_PAGE_RECEIVED, 1'b0, 11'd0), 1'b0, RSP_QUIET});
      directed_table.push_back(directed_row_type'{
         word_of(OP_COMPLAINT, CC_EOF_OK, 1'b1, 11'd2), 1'b0, RSP_QUIET});
      directed_table.push_back(directed_row_type'{
         word_of(OP_CLEAR_ALL, CC_PAGE_RECEIVED, 1'b0, 11'd0), 1'b0, RSP_QUIET});
      directed_table.push_back(directed_row_type'{
         word_of(OP_SPARE_LO, CC_UNKNOWN_HI, 1'b1, 11'h7FF), 1'b0, RSP_QUIET});
      directed_table.push_back(directed_row_type'{
         word_of(OP_SPARE_HI, CC_LAST_MISSING, 1'b1, 11'd2), 1'b0, RSP_QUIET});

      // Hold reset, then program while the start-up sweep runs
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      load_settings(4, 2, 2);

      send_idle_pct = 10;
      recv_idle_pct = 59;
      foreach (directed_table[i])
         send_word(directed_table[i].w, directed_table[i].typed, directed_table[i].want);
      settle();

      for (int p = 0; p < PHASES; p++) begin
         load_settings(phase_pages[p], phase_ticks[p], phase_retries[p]);
         // sender-light idling, then receiver-light, then none at all
         if (p < 2) begin
            send_idle_pct = 10;
            recv_idle_pct = 59;
         end else if (p < 4) begin
            send_idle_pct = 59;
            recv_idle_pct = 10;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         repeat (ITEMS_PER_PHASE) begin
            w = random_word();
            send_word(w, 1'b0, RSP_QUIET);
         end
         settle();
      end

      if (!fault_seen)
         $display("nak_missing_page_tracker regression: pass");
      else
         $display("nak_missing_page_tracker regression: fail");
      $finish;
   end

endmodule
